@@ rtl/core/mips_pkg.sv @@
// Shared types and constants for the MIPS32 core: controller states,
// command/status structs, opcode and function codes. No dependencies.
`default_nettype none
package mips_pkg;

  localparam int IN_W  = 48;
  localparam int OUT_W = 176;

  localparam logic [31:0] PC_HALT  = 32'hFFFF_FFFF;
  localparam logic [31:0] SP_RESET = 32'h0100_0000;
  localparam logic [31:0] RA_RESET = 32'hFFFF_FFFF;

  localparam logic [4:0] REG_V0 = 5'd2;
  localparam logic [4:0] REG_SP = 5'd29;
  localparam logic [4:0] REG_RA = 5'd31;

  localparam logic [1:0] FMT_R = 2'd0;
  localparam logic [1:0] FMT_I = 2'd1;
  localparam logic [1:0] FMT_J = 2'd2;

  // opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_SLTIU = 6'h0B;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2B;
  localparam logic [5:0] OP_LL    = 6'h30;
  localparam logic [5:0] OP_SC    = 6'h38;

  // R-format function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_MUL  = 6'h19;
  localparam logic [5:0] FN_DIV  = 6'h1A;
  localparam logic [5:0] FN_DIVU = 6'h1B;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_DECODE, S_EXEC, S_DIV, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    LD_NONE, LD_WORD, LD_BYTE, LD_BYTEU, LD_HALF, LD_HALFU
  } ld_t;

  typedef enum logic [1:0] {
    SW_NONE, SW_WORD, SW_BYTE, SW_HALF
  } sw_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic fetch;
    logic decode;
    logic execute;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic step_req;
    logic div_go;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/core/mips_div.sv @@
// Iterative 32-bit divider, one quotient bit per cycle, signed or unsigned.
// Depends on mips_pkg (style only).
`default_nettype none
module mips_div
  import mips_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        sgn,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [31:0]      quo,
  output logic [31:0]      rem
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] q, r, dvs;
  logic        neg_q, neg_r;
  logic [32:0] r_sh, diff;

  assign r_sh = {r, q[31]};
  assign diff = r_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= (sgn && a[31]) ? (32'd0 - a) : a;
      dvs   <= (sgn && b[31]) ? (32'd0 - b) : b;
      r     <= '0;
      neg_q <= sgn && (a[31] ^ b[31]);
      neg_r <= sgn && a[31];
    end else if (busy) begin
      r <= diff[32] ? r_sh[31:0] : diff[31:0];
      q <= {q[30:0], ~diff[32]};
    end
  end

  assign quo = neg_q ? (32'd0 - q) : q;
  assign rem = neg_r ? (32'd0 - r) : r;

endmodule
`default_nettype wire

@@ rtl/core/mips_ctrl.sv @@
// Sequencing state machine of the core: memory clear, accept, fetch,
// decode, execute, divide wait, commit. Depends on mips_pkg.
`default_nettype none
module mips_ctrl
  import mips_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (sts.clear_last) state_next = S_IDLE;
      S_IDLE:   if (s_tvalid) state_next = sts.step_req ? S_FETCH : S_DONE;
      S_FETCH:  state_next = S_DECODE;
      S_DECODE: state_next = S_EXEC;
      S_EXEC:   state_next = sts.div_go ? S_DIV : S_DONE;
      S_DIV:    if (sts.div_done) state_next = S_DONE;
      S_DONE:   if (sts.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    s_tready     = 1'b0;
    case (state)
      S_CLEAR:  cmd.clear_wr = 1'b1;
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      S_FETCH:  cmd.fetch   = 1'b1;
      S_DECODE: cmd.decode  = 1'b1;
      S_EXEC:   cmd.execute = 1'b1;
      S_DONE:   cmd.commit  = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/mips_dp.sv @@
// Datapath of the core: unified memory, register file, ALU, divider,
// architectural registers and the result register. Depends on mips_pkg, mips_div.
`default_nettype none
module mips_dp
  import mips_pkg::*;
#(
  parameter int MEM_WORDS = 65536
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IN_W-1:0]  s_tdata,
  input  wire logic             s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata,
  output logic                  m_tuser,
  input  wire cmd_t             cmd,
  output sts_t                  sts
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [29:0] MEM_LIMIT = 30'(MEM_WORDS);

  // architectural state
  logic [31:0] pc, hi, lo, v0;
  logic [31:0] rf [32];
  logic [31:0] rf_vld;

  // latched input word
  logic        pre_step, pre_halt;
  logic [15:0] pre_idx;
  logic [31:0] pre_word;
  logic        step_exec;

  // memory
  logic [31:0] mem [MEM_WORDS];
  logic [31:0] mem_q;
  logic [AW-1:0] clr_idx, mem_ra, mem_wa;
  logic [31:0] mem_wd;
  logic        mem_re, mem_we, rd_ok;

  // decode / execute
  logic [31:0] ir, ra, rb, word_in;
  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sh;
  logic [31:0] imm, simm, ea, pc4;
  logic        pc_ok, ea_ok, pre_ok;

  logic [1:0]  e_fmt;
  logic        e_wr, e_div_go, e_mem;
  logic [4:0]  e_dreg;
  logic [31:0] e_val, e_npc;
  ld_t         e_ld;
  sw_t         e_st;

  logic [1:0]  ex_fmt;
  logic        ex_wr, ex_div;
  logic [4:0]  ex_dreg;
  logic [31:0] ex_val, ex_npc, ex_maddr, ex_b;
  ld_t         ex_ld;
  sw_t         ex_st;

  logic [31:0] ldw, wb_val, st_word;
  logic        wb_wr, wb_mw, wb_v0;

  logic        div_done;
  logic [31:0] div_quo, div_rem;

  // result register
  logic        o_halt, o_wr, o_mw;
  logic [31:0] o_word, o_npc, o_dval, o_maddr, o_ret;
  logic [1:0]  o_fmt;
  logic [4:0]  o_dreg;

  function automatic logic [31:0] rf_reset_val(input logic [4:0] i);
    logic [31:0] v;
    v = '0;
    if (i == REG_SP) v = SP_RESET;
    if (i == REG_RA) v = RA_RESET;
    return v;
  endfunction

  assign step_exec = pre_step && !pre_halt;
  assign pc4       = pc + 32'd4;
  assign pc_ok     = pc[31:2] < MEM_LIMIT;
  assign pre_ok    = {14'd0, pre_idx} < MEM_LIMIT;

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pre_step <= s_tuser;
      pre_halt <= s_tuser && (pc == PC_HALT);
      pre_idx  <= s_tdata[15:0];
      pre_word <= s_tdata[47:16];
    end
  end

  // memory clear sweep
  always_ff @(posedge clk) begin
    if (rst)               clr_idx <= '0;
    else if (cmd.clear_wr) clr_idx <= clr_idx + AW'(1);
  end

  assign mem_re = cmd.fetch || cmd.execute;
  assign mem_ra = cmd.fetch ? pc[AW+1:2] : ea[AW+1:2];
  assign wb_mw  = step_exec && (ex_st != SW_NONE) && rd_ok;
  assign mem_we = cmd.clear_wr ||
                  (cmd.commit && ((!pre_step && pre_ok) || wb_mw));
  assign mem_wa = cmd.clear_wr ? clr_idx :
                  (!pre_step ? AW'({14'd0, pre_idx}) : ex_maddr[AW+1:2]);
  assign mem_wd = cmd.clear_wr ? 32'd0 : (!pre_step ? pre_word : st_word);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch)        rd_ok <= pc_ok;
    else if (cmd.execute) rd_ok <= ea_ok;
  end

  // decode: latch instruction and read both source registers
  assign word_in = rd_ok ? mem_q : 32'd0;

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      ir <= word_in;
      ra <= rf_vld[word_in[25:21]] ? rf[word_in[25:21]] : rf_reset_val(word_in[25:21]);
      rb <= rf_vld[word_in[20:16]] ? rf[word_in[20:16]] : rf_reset_val(word_in[20:16]);
    end
  end

  assign op   = ir[31:26];
  assign rt   = ir[20:16];
  assign rd   = ir[15:11];
  assign sh   = ir[10:6];
  assign fn   = ir[5:0];
  assign imm  = {16'd0, ir[15:0]};
  assign simm = {{16{ir[15]}}, ir[15:0]};
  assign ea   = ra + simm;
  assign ea_ok = ea[31:2] < MEM_LIMIT;

  always_comb begin
    e_fmt    = FMT_I;
    e_wr     = 1'b0;
    e_dreg   = rt;
    e_val    = '0;
    e_npc    = pc4;
    e_ld     = LD_NONE;
    e_st     = SW_NONE;
    e_mem    = 1'b0;
    e_div_go = 1'b0;
    if (op == OP_RTYPE) begin
      e_fmt  = FMT_R;
      e_dreg = rd;
      e_wr   = 1'b1;
      case (fn)
        FN_ADD, FN_ADDU: e_val = ra + rb;
        FN_SUB, FN_SUBU: e_val = ra - rb;
        FN_AND:  e_val = ra & rb;
        FN_OR:   e_val = ra | rb;
        FN_NOR:  e_val = ~(ra | rb);
        FN_SLT:  e_val = {31'd0, $signed(ra) < $signed(rb)};
        FN_SLTU: e_val = {31'd0, ra < rb};
        FN_SLL:  e_val = rb << sh;
        FN_SRL:  e_val = rb >> sh;
        FN_MUL:  e_val = ra * rb;
        FN_DIV, FN_DIVU: begin
          e_wr     = 1'b0;
          e_div_go = (rb != 32'd0);
        end
        FN_JR: begin
          e_wr  = 1'b0;
          e_npc = ra;
        end
        default: e_wr = 1'b0;
      endcase
    end else if (op == OP_J || op == OP_JAL) begin
      e_fmt = FMT_J;
      e_npc = {pc4[31:28], ir[25:0], 2'b00};
      if (op == OP_JAL) begin
        e_wr   = 1'b1;
        e_dreg = REG_RA;
        e_val  = pc + 32'd8;
      end
    end else begin
      e_wr = 1'b1;
      case (op)
        OP_ADDI, OP_ADDIU: e_val = ea;
        OP_ANDI:  e_val = ra & imm;
        OP_ORI:   e_val = ra | imm;
        OP_SLTI:  e_val = {31'd0, $signed(ra) < $signed(simm)};
        OP_SLTIU: e_val = {31'd0, ra < simm};
        OP_LUI:   e_val = {ir[15:0], 16'd0};
        OP_BEQ, OP_BNE: begin
          e_wr = 1'b0;
          if ((ra == rb) == (op == OP_BEQ)) e_npc = pc4 + {simm[29:0], 2'b00};
        end
        OP_LW, OP_LL: begin e_mem = 1'b1; e_ld = LD_WORD;  end
        OP_LB:        begin e_mem = 1'b1; e_ld = LD_BYTE;  end
        OP_LBU:       begin e_mem = 1'b1; e_ld = LD_BYTEU; end
        OP_LH:        begin e_mem = 1'b1; e_ld = LD_HALF;  end
        OP_LHU:       begin e_mem = 1'b1; e_ld = LD_HALFU; end
        OP_SW: begin e_wr = 1'b0; e_mem = 1'b1; e_st = SW_WORD; end
        OP_SB: begin e_wr = 1'b0; e_mem = 1'b1; e_st = SW_BYTE; end
        OP_SH: begin e_wr = 1'b0; e_mem = 1'b1; e_st = SW_HALF; end
        OP_SC: begin e_mem = 1'b1; e_st = SW_WORD; e_val = 32'd1; end
        default: e_wr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      ex_fmt   <= e_fmt;
      ex_wr    <= e_wr && (e_dreg != 5'd0);
      ex_dreg  <= e_dreg;
      ex_val   <= e_val;
      ex_npc   <= e_npc;
      ex_ld    <= e_ld;
      ex_st    <= e_st;
      ex_maddr <= e_mem ? ea : 32'd0;
      ex_b     <= rb;
      ex_div   <= e_div_go;
    end
  end

  mips_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.execute && e_div_go),
    .sgn   (fn == FN_DIV),
    .a     (ra),
    .b     (rb),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // load shaping and sub-word store merge; mem_q holds the word at ea
  assign ldw = rd_ok ? mem_q : 32'd0;

  always_comb begin
    case (ex_ld)
      LD_WORD:  wb_val = ldw;
      LD_BYTE:  wb_val = {{24{ldw[7]}}, ldw[7:0]};
      LD_BYTEU: wb_val = {24'd0, ldw[7:0]};
      LD_HALF:  wb_val = {{16{ldw[15]}}, ldw[15:0]};
      LD_HALFU: wb_val = {16'd0, ldw[15:0]};
      default:  wb_val = ex_val;
    endcase
    case (ex_st)
      SW_BYTE: st_word = {ldw[31:8], ex_b[7:0]};
      SW_HALF: st_word = {ldw[31:16], ex_b[15:0]};
      default: st_word = ex_b;
    endcase
  end

  assign wb_wr = step_exec && ex_wr;
  assign wb_v0 = wb_wr && (ex_dreg == REG_V0);

  // commit
  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= '0;
      hi     <= '0;
      lo     <= '0;
      v0     <= '0;
      rf_vld <= '0;
    end else if (cmd.commit) begin
      if (step_exec) pc <= ex_npc;
      if (step_exec && ex_div) begin
        hi <= div_rem;
        lo <= div_quo;
      end
      if (wb_v0) v0 <= wb_val;
      if (wb_wr) rf_vld[ex_dreg] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wb_wr) rf[ex_dreg] <= wb_val;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst)             m_tvalid <= 1'b0;
    else if (cmd.commit) m_tvalid <= 1'b1;
    else if (m_tready)   m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_halt  <= pre_halt;
      o_word  <= step_exec ? ir : 32'd0;
      o_fmt   <= step_exec ? ex_fmt : FMT_R;
      o_npc   <= step_exec ? ex_npc : pc;
      o_wr    <= wb_wr;
      o_dreg  <= wb_wr ? ex_dreg : 5'd0;
      o_dval  <= wb_wr ? wb_val : 32'd0;
      o_mw    <= wb_mw;
      o_maddr <= step_exec ? ex_maddr : 32'd0;
      o_ret   <= wb_v0 ? wb_val : v0;
    end
  end

  assign m_tuser = o_halt;
  assign m_tdata = {7'd0, o_ret, o_maddr, o_mw, o_dval, o_dreg, o_wr, o_npc, o_fmt, o_word};

  assign sts.clear_last = (clr_idx == AW'(MEM_WORDS - 1));
  assign sts.step_req   = s_tuser && (pc != PC_HALT);
  assign sts.div_go     = e_div_go;
  assign sts.div_done   = div_done;
  assign sts.out_free   = !m_tvalid || m_tready;

endmodule
`default_nettype wire

@@ rtl/core/mips32_single_cycle_core.sv @@
// Top level of the MIPS32 core: controller plus datapath.
// Depends on mips_pkg, mips_ctrl, mips_dp (and mips_div below it).
//
// Input channel s_*: each word is a preload (s_tuser = 0) that writes
// preload_word to memory word preload_index, or a step (s_tuser = 1) that
// runs one instruction at pc. Output channel m_*: one result word per input
// word, in order; m_tuser carries the halt flag.
// A preload or a halted step goes from accept straight to commit; an instruction
// step passes through fetch, decode and execute, and div/divu with a nonzero
// divisor also waits for the divider. One word is in flight at a time; the core
// is ready to accept again once the result register loads.
// The result register lets the next word be accepted while a result waits;
// if m_tready stays low, the core holds the finished work until it is free.
// Reset: registers return to their reset values and a clearing pass writes
// zero to all MEM_WORDS memory words, one per cycle, with s_tready low until
// it ends.
`default_nettype none
module mips32_single_cycle_core
  import mips_pkg::*;
#(
  parameter int MEM_WORDS = 65536
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // preload_index [15:0], preload_word [47:16]
  input  wire logic [IN_W-1:0]  s_tdata,
  // operation [0]
  input  wire logic             s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // executed_word [31:0], format_class [33:32], next_pc [65:34],
  // reg_written [66], dest_reg [71:67], dest_value [103:72],
  // mem_written [104], mem_byte_addr [136:105], return_value [168:137]
  output logic [OUT_W-1:0]      m_tdata,
  // halted [0]
  output logic                  m_tuser
);

  cmd_t cmd;
  sts_t sts;

  mips_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mips_dp #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking bench for mips32_single_cycle_core: preloads small programs,
// steps them and compares every result word against a behavioral CPU model.
// Depends on mips_pkg and the core RTL.
`timescale 1ns / 100ps
module tb_top;
  import mips_pkg::*;

  typedef struct packed {
    logic        op;
    logic [15:0] idx;
    logic [31:0] wrd;
  } item_t;

  typedef struct {
    logic        halted;
    logic [31:0] word;
    logic [1:0]  fmt;
    logic [31:0] npc;
    logic        wr;
    logic [4:0]  dreg;
    logic [31:0] dval;
    logic        mw;
    logic [31:0] maddr;
    logic [31:0] v0;
  } cpu_res_t;

  localparam int MEMW = 65536;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser;

  mips32_single_cycle_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // architectural state of the model
  logic [31:0] gpr [32];
  logic [31:0] pc, hi, lo;
  logic [31:0] mem [MEMW];

  item_t    pending[$];
  cpu_res_t expected[$];
  int       errors = 0;
  int       send_idle = 0;
  int       recv_idle = 0;
  int       sent_cnt = 0;
  int       acc_cnt = 0;
  bit       hold_send = 0;
  bit       paused = 0;

  function automatic logic [31:0] sx16(logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  function automatic logic [31:0] mem_rd(logic [31:0] a);
    return (a[31:2] < MEMW) ? mem[a[31:2]] : 32'h0;
  endfunction

  function automatic logic mem_wr(logic [31:0] a, logic [31:0] v, logic [31:0] keep);
    if (a[31:2] >= MEMW) return 1'b0;
    mem[a[31:2]] = (mem[a[31:2]] & keep) | (v & ~keep);
    return 1'b1;
  endfunction

  function automatic cpu_res_t cpu_step(item_t it);
    cpu_res_t r;
    logic [31:0] w, a, b, simm, imm, addr, q, rm, ua, ub;
    logic [5:0] op, fn;
    logic [4:0] rs, rt, rd, sh;
    r = '{default: '0};
    r.npc = pc;
    if (!it.op) begin
      mem[it.idx] = it.wrd;
    end else if (pc == PC_HALT) begin
      r.halted = 1'b1;
    end else begin
      w = mem_rd(pc);
      r.word = w;
      op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
      sh = w[10:6]; fn = w[5:0];
      imm = {16'h0, w[15:0]};
      simm = sx16(w);
      a = gpr[rs]; b = gpr[rt];
      addr = a + simm;
      r.npc = pc + 32'd4;
      if (op == OP_RTYPE) begin
        r.fmt = FMT_R; r.wr = 1'b1; r.dreg = rd;
        case (fn)
          FN_ADD, FN_ADDU: r.dval = a + b;
          FN_SUB, FN_SUBU: r.dval = a - b;
          FN_AND:  r.dval = a & b;
          FN_OR:   r.dval = a | b;
          FN_NOR:  r.dval = ~(a | b);
          FN_SLT:  r.dval = {31'h0, $signed(a) < $signed(b)};
          FN_SLTU: r.dval = {31'h0, a < b};
          FN_SLL:  r.dval = b << sh;
          FN_SRL:  r.dval = b >> sh;
          FN_MUL:  r.dval = a * b;
          FN_DIV: begin
            r.wr = 1'b0;
            if (b != 32'd0) begin
              ua = a[31] ? -a : a;
              ub = b[31] ? -b : b;
              q = ua / ub; rm = ua % ub;
              lo = (a[31] != b[31]) ? -q : q;
              hi = a[31] ? -rm : rm;
            end
          end
          FN_DIVU: begin
            r.wr = 1'b0;
            if (b != 32'd0) begin lo = a / b; hi = a % b; end
          end
          FN_JR: begin r.wr = 1'b0; r.npc = a; end
          default: r.wr = 1'b0;
        endcase
      end else if (op == OP_J || op == OP_JAL) begin
        r.fmt = FMT_J;
        r.npc = {r.npc[31:28], w[25:0], 2'b00};
        if (op == OP_JAL) begin r.wr = 1'b1; r.dreg = REG_RA; r.dval = pc + 32'd8; end
      end else begin
        r.fmt = FMT_I; r.wr = 1'b1; r.dreg = rt;
        case (op)
          OP_ADDI, OP_ADDIU: r.dval = addr;
          OP_ANDI:  r.dval = a & imm;
          OP_ORI:   r.dval = a | imm;
          OP_SLTI:  r.dval = {31'h0, $signed(a) < $signed(simm)};
          OP_SLTIU: r.dval = {31'h0, a < simm};
          OP_LUI:   r.dval = imm << 16;
          OP_BEQ, OP_BNE: begin
            r.wr = 1'b0;
            if ((a == b) == (op == OP_BEQ)) r.npc = pc + 32'd4 + (simm << 2);
          end
          OP_LW, OP_LL: begin r.maddr = addr; r.dval = mem_rd(addr); end
          OP_LB:  begin r.maddr = addr; q = mem_rd(addr); r.dval = {{24{q[7]}}, q[7:0]}; end
          OP_LBU: begin r.maddr = addr; r.dval = mem_rd(addr) & 32'hFF; end
          OP_LH:  begin r.maddr = addr; r.dval = sx16(mem_rd(addr)); end
          OP_LHU: begin r.maddr = addr; r.dval = mem_rd(addr) & 32'hFFFF; end
          OP_SW: begin r.wr = 1'b0; r.maddr = addr; r.mw = mem_wr(addr, b, 32'h0); end
          OP_SB: begin r.wr = 1'b0; r.maddr = addr; r.mw = mem_wr(addr, b, 32'hFFFFFF00); end
          OP_SH: begin r.wr = 1'b0; r.maddr = addr; r.mw = mem_wr(addr, b, 32'hFFFF0000); end
          OP_SC: begin r.maddr = addr; r.mw = mem_wr(addr, b, 32'h0); r.dval = 32'd1; end
          default: r.wr = 1'b0;
        endcase
      end
      if (r.wr && r.dreg == 5'd0) r.wr = 1'b0;
      if (r.wr) gpr[r.dreg] = r.dval;
      else begin r.dreg = 5'd0; r.dval = 32'd0; end
      pc = r.npc;
    end
    r.v0 = gpr[REG_V0];
    return r;
  endfunction

  // driver: changes inputs on the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && (acc_cnt != sent_cnt)) begin
        // hold the word until it is taken
      end else if (pending.size() != 0 && !hold_send && ($urandom_range(99) >= send_idle)) begin
        s_tvalid <= 1'b1;
        s_tuser  <= pending[0].op;
        s_tdata  <= {pending[0].wrd, pending[0].idx};
        sent_cnt++;
      end else begin
        s_tvalid <= 1'b0;
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor: samples at the rising edge
  always @(posedge clk) begin
    cpu_res_t e;
    if (!rst && s_tvalid && s_tready) begin
      acc_cnt++;
      expected.push_back(cpu_step(pending.pop_front()));
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, m_tdata);
      end else begin
        e = expected.pop_front();
        if (m_tuser !== e.halted || m_tdata[31:0] !== e.word || m_tdata[33:32] !== e.fmt
            || m_tdata[65:34] !== e.npc || m_tdata[66] !== e.wr
            || m_tdata[71:67] !== e.dreg || m_tdata[103:72] !== e.dval
            || m_tdata[104] !== e.mw || m_tdata[136:105] !== e.maddr
            || m_tdata[168:137] !== e.v0) begin
          errors++;
          $display("%0t: mismatch exp halt=%b word=%h fmt=%0d npc=%h wr=%b rd=%0d val=%h mw=%b addr=%h v0=%h",
                   $time, e.halted, e.word, e.fmt, e.npc, e.wr, e.dreg, e.dval, e.mw,
                   e.maddr, e.v0);
          $display("%0t:          got halt=%b word=%h fmt=%0d npc=%h wr=%b rd=%0d val=%h mw=%b addr=%h v0=%h",
                   $time, m_tuser, m_tdata[31:0], m_tdata[33:32], m_tdata[65:34], m_tdata[66],
                   m_tdata[71:67], m_tdata[103:72], m_tdata[104], m_tdata[136:105],
                   m_tdata[168:137]);
        end
      end
    end
  end

  task automatic add_item(logic op, logic [15:0] idx, logic [31:0] wrd);
    pending.push_back('{op, idx, wrd});
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || expected.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rtype(logic [4:0] rs, rt, rd, sh, logic [5:0] fn);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, rt, logic [15:0] im);
    return {op, rs, rt, im};
  endfunction

  // random instruction biased toward legal encodings and low data addresses
  function automatic logic [31:0] rand_instr();
    logic [5:0] fns [15] = '{FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_NOR,
                             FN_SLT, FN_SLTU, FN_SLL, FN_SRL, FN_MUL, FN_DIV, FN_DIVU, FN_ADD};
    logic [5:0] ops [22] = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_LUI,
                             OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW,
                             OP_LL, OP_SC, OP_BEQ, OP_BNE, OP_ADDI, OP_ORI, OP_LW};
    logic [4:0] rs;
    logic [5:0] op;
    int k;
    k = $urandom_range(99);
    rs = 5'($urandom_range(31));
    if (k < 3) return $urandom;
    if (k < 45)
      return rtype(rs, 5'($urandom), 5'($urandom), 5'($urandom), fns[$urandom_range(14)]);
    op = ops[$urandom_range(21)];
    // memory ops use r0, sp or the base register r8 to stay mostly in range
    if (op >= OP_LB) rs = ($urandom_range(3) == 0) ? REG_SP : (($urandom_range(1)) ? 5'd0 : 5'd8);
    if (op == OP_BEQ || op == OP_BNE)
      return itype(op, rs, 5'($urandom), 16'($urandom_range(6)) - 16'd2);
    if (op >= OP_LB) return itype(op, rs, 5'($urandom), 16'($urandom_range(255)));
    return itype(op, rs, 5'($urandom), 16'($urandom));
  endfunction

  initial begin : stimulus
    int n, base, len, steps;
    gpr = '{default: 32'h0};
    gpr[REG_SP] = SP_RESET;
    gpr[REG_RA] = RA_RESET;
    pc = 0; hi = 0; lo = 0;
    mem = '{default: 32'h0};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed program at word 0
    add_item(1'b0, 16'hFFFF, 32'hFFFF_FFFF);
    add_item(1'b0, 16'd0,  itype(OP_LUI, 5'd0, 5'd8, 16'h8000));
    add_item(1'b0, 16'd1,  itype(OP_ADDI, 5'd0, 5'd9, 16'hFFFF));
    add_item(1'b0, 16'd2,  rtype(5'd8, 5'd9, 5'd10, 5'd0, FN_DIV));
    add_item(1'b0, 16'd3,  rtype(5'd8, 5'd0, 5'd0, 5'd0, FN_DIVU));
    add_item(1'b0, 16'd4,  rtype(5'd8, 5'd9, 5'd11, 5'd0, FN_SLTU));
    add_item(1'b0, 16'd5,  rtype(5'd0, 5'd8, 5'd12, 5'd31, FN_SRL));
    add_item(1'b0, 16'd6,  rtype(5'd8, 5'd9, 5'd0, 5'd0, FN_ADD));
    add_item(1'b0, 16'd7,  itype(OP_ORI, 5'd0, 5'd8, 16'h0400));
    add_item(1'b0, 16'd8,  itype(OP_SC, 5'd8, 5'd9, 16'h0));
    add_item(1'b0, 16'd9,  itype(OP_SB, 5'd8, 5'd9, 16'h0));
    add_item(1'b0, 16'd10, itype(OP_LB, 5'd8, 5'd2, 16'h0));
    add_item(1'b0, 16'd11, itype(OP_LH, 5'd8, 5'd2, 16'h3));
    add_item(1'b0, 16'd12, itype(OP_SW, REG_SP, 5'd9, 16'h0));
    add_item(1'b0, 16'd13, itype(OP_LW, REG_SP, 5'd2, 16'h0));
    add_item(1'b0, 16'd14, {OP_JAL, 26'd16});
    add_item(1'b0, 16'd16, 32'hFC00_0000);
    add_item(1'b0, 16'd17, rtype(REG_RA, 5'd0, 5'd0, 5'd0, FN_JR));
    for (int i = 0; i < 19; i++) add_item(1'b1, 16'd0, 32'd0);
    add_item(1'b1, 16'hFFFF, 32'hFFFF_FFFF); // another step at word 16, where jr $ra returns to
    wait_drained();

    // random phases; each program restarts via j from a fresh block
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 87 : 36) : 0;
      recv_idle = (ph == 2) ? 87 : ((ph == 3) ? 36 : 0);
      n = 0;
      while (n < 150) begin
        base = 64 + $urandom_range(900) * 8;
        len = $urandom_range(4, 12);
        for (int i = 0; i < len; i++) add_item(1'b0, 16'(base + i), rand_instr());
        // occasionally exit via jr $ra (ra may be 0xFFFFFFFF -> halt)
        add_item(1'b0, 16'(base + len), rtype(REG_RA, 5'd0, 5'd0, 5'd0, FN_JR));
        add_item(1'b0, 16'(base + len + 1), {OP_J, 26'(base)});
        // put a zero word after the loop jump
        add_item(1'b0, 16'(base + len + 2), 32'h0);
        // preload a jump at current pc's word when in range
        if (pc != PC_HALT && pc[31:2] < MEMW)
          add_item(1'b0, 16'(pc[31:2]), {OP_J, 26'(base)});
        else begin
          add_item(1'b1, 16'd0, 32'd0); // halt step or dead fetch
          add_item(1'b0, 16'($urandom), $urandom);
        end
        steps = $urandom_range(6, 20);
        for (int i = 0; i < steps; i++) add_item(1'b1, 16'($urandom), $urandom);
        n += len + 3 + steps;
        if (ph == 0 && n > 60 && !paused) begin
          paused = 1;
          hold_send = 1;
          while (expected.size() != 0 || acc_cnt != sent_cnt) @(posedge clk);
          hold_send = 0;
        end
        while (pending.size() > 40) @(posedge clk);
        wait_drained();
        // if pc is halted or out of range, add a step when halted and drain
        if (pc == PC_HALT || pc[31:2] >= MEMW) begin
          if (pc == PC_HALT) add_item(1'b1, 16'd0, 32'd0);
          wait_drained();
        end
      end
      wait_drained();
    end
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

@@ mips32_single_cycle_core.f @@
rtl/core/mips_pkg.sv
rtl/core/mips_div.sv
rtl/core/mips_ctrl.sv
rtl/core/mips_dp.sv
rtl/core/mips32_single_cycle_core.sv
tb/sv/tb_top.sv
